// ===== rtl/operand_stack_with_dup_swap_unit_defines.svh =====
// Assertion macros shared by the operand stack checkers.
// Each macro expects a signal named clock and a signal named reset in scope.
`ifndef OPERAND_STACK_WITH_DUP_SWAP_UNIT_DEFINES_SVH
`define OPERAND_STACK_WITH_DUP_SWAP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define OPSTK_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("operand stack check failed");

// Consequent must hold in the cycle after the antecedent
`define OPSTK_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("operand stack check failed");

`endif

// ===== rtl/opstk_pkg.sv =====
`timescale 1ns / 1ps

package opstk_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 128;
   localparam int SP_W        = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);

   // Field widths
   localparam int OP_W     = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int DEPTH_W  = 8;

   // Beat layout
   localparam int REQ_TDATA_W  = VALUE_W;
   localparam int RSP_FIELDS_W = VALUE_W + STATUS_W + DEPTH_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int STATUS_LSB   = VALUE_W;
   localparam int DEPTH_LSB    = VALUE_W + STATUS_W;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_PEEK  = 3'd2,
      OP_DUP   = 3'd3,
      OP_SWAP  = 3'd4,
      OP_CLEAR = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_SHORT = 2'd3
   } st_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_READ,
      S_DUP_WR,
      S_SWAP_RD2,
      S_SWAP_WR1,
      S_SWAP_WR2
   } state_type;

   typedef enum logic [1:0] {
      ADDR_TOP,
      ADDR_BELOW,
      ADDR_FREE
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_PUSH,
      WD_READ,
      WD_HOLD
   } wd_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_EMPTY,
      RES_READ
   } res_sel_type;

   typedef enum logic [1:0] {
      SP_KEEP,
      SP_INC,
      SP_DEC,
      SP_CLEAR
   } sp_op_type;

   // Controller to datapath
   typedef struct packed {
      logic         latch_req;
      logic         ram_en;
      logic         ram_we;
      addr_sel_type addr_sel;
      wd_sel_type   wd_sel;
      logic         hold_load;
      logic         finish;
      res_sel_type  res_sel;
      st_type       status;
      sp_op_type    sp_op;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   short_stk;
      logic   slot_free;
   } stat_type;

endpackage

// ===== rtl/opstk_ram.sv =====
`timescale 1ns / 1ps

module opstk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Single port: write, or read into the output register and hold it
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rd_data_ff <= mem_ff[addr];
         end
      end
   end

   assign rdata = rd_data_ff;

endmodule

// ===== rtl/opstk_ctrl.sv =====
`timescale 1ns / 1ps

module opstk_ctrl import opstk_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Sequence one request at a time
   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.addr_sel = ADDR_TOP;
      cmd.wd_sel   = WD_PUSH;
      cmd.res_sel  = RES_ZERO;
      cmd.status   = ST_OK;
      cmd.sp_op    = SP_KEEP;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = S_EXEC;
            end
         end

         S_EXEC: begin
            case (stat.op)
               OP_PUSH: begin
                  if (stat.slot_free) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.ram_en   = 1'b1;
                        cmd.ram_we   = 1'b1;
                        cmd.addr_sel = ADDR_FREE;
                        cmd.wd_sel   = WD_PUSH;
                        cmd.sp_op    = SP_INC;
                     end
                  end
               end

               OP_POP, OP_PEEK: begin
                  if (stat.empty) begin
                     if (stat.slot_free) begin
                        cmd.finish  = 1'b1;
                        cmd.res_sel = RES_EMPTY;
                        cmd.status  = ST_EMPTY;
                        state_in    = S_IDLE;
                     end
                  end else begin
                     cmd.ram_en   = 1'b1;
                     cmd.addr_sel = ADDR_TOP;
                     state_in     = S_READ;
                  end
               end

               OP_DUP: begin
                  if (stat.empty || stat.full) begin
                     if (stat.slot_free) begin
                        cmd.finish = 1'b1;
                        cmd.status = stat.empty ? ST_EMPTY : ST_FULL;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     cmd.ram_en   = 1'b1;
                     cmd.addr_sel = ADDR_TOP;
                     state_in     = S_DUP_WR;
                  end
               end

               OP_SWAP: begin
                  if (stat.short_stk) begin
                     if (stat.slot_free) begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_SHORT;
                        state_in   = S_IDLE;
                     end
                  end else begin
                     cmd.ram_en   = 1'b1;
                     cmd.addr_sel = ADDR_TOP;
                     state_in     = S_SWAP_RD2;
                  end
               end

               OP_CLEAR: begin
                  if (stat.slot_free) begin
                     cmd.finish = 1'b1;
                     cmd.sp_op  = SP_CLEAR;
                     state_in   = S_IDLE;
                  end
               end

               // Unused codes: answer ok and leave the stack alone
               default: begin
                  if (stat.slot_free) begin
                     cmd.finish = 1'b1;
                     state_in   = S_IDLE;
                  end
               end
            endcase
         end

         // Top word sits in the RAM read register
         S_READ: begin
            if (stat.slot_free) begin
               cmd.finish  = 1'b1;
               cmd.res_sel = RES_READ;
               cmd.sp_op   = (stat.op == OP_POP) ? SP_DEC : SP_KEEP;
               state_in    = S_IDLE;
            end
         end

         // Copy the top word into the free slot
         S_DUP_WR: begin
            if (stat.slot_free) begin
               cmd.ram_en   = 1'b1;
               cmd.ram_we   = 1'b1;
               cmd.addr_sel = ADDR_FREE;
               cmd.wd_sel   = WD_READ;
               cmd.sp_op    = SP_INC;
               cmd.finish   = 1'b1;
               state_in     = S_IDLE;
            end
         end

         // Keep the top word, fetch the one below
         S_SWAP_RD2: begin
            cmd.hold_load = 1'b1;
            cmd.ram_en    = 1'b1;
            cmd.addr_sel  = ADDR_BELOW;
            state_in      = S_SWAP_WR1;
         end

         // Lower word goes on top
         S_SWAP_WR1: begin
            cmd.ram_en   = 1'b1;
            cmd.ram_we   = 1'b1;
            cmd.addr_sel = ADDR_TOP;
            cmd.wd_sel   = WD_READ;
            state_in     = S_SWAP_WR2;
         end

         // Old top word goes below
         S_SWAP_WR2: begin
            if (stat.slot_free) begin
               cmd.ram_en   = 1'b1;
               cmd.ram_we   = 1'b1;
               cmd.addr_sel = ADDR_BELOW;
               cmd.wd_sel   = WD_HOLD;
               cmd.finish   = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/opstk_dp.sv =====
`timescale 1ns / 1ps

module opstk_dp import opstk_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [OP_W-1:0]        req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  cmd_type                cmd,
   output stat_type               stat,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   op_type               op_ff, op_in;
   logic [VALUE_W-1:0]   value_ff, value_in;
   logic [SP_W-1:0]      sp_ff, sp_in;
   logic [VALUE_W-1:0]   hold_ff, hold_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]   result_ff, result_in;
   st_type               status_ff, status_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;

   logic [SP_W-1:0]         sp_m1;
   logic [SP_W-1:0]         sp_m2;
   logic [ADDR_W-1:0]       ram_addr;
   logic [VALUE_W-1:0]      ram_wdata;
   logic [VALUE_W-1:0]      ram_rdata;
   logic [SP_W+DEPTH_W-1:0] depth_wide;

   // Stack storage
   opstk_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (cmd.ram_en),
      .we    (cmd.ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // Address and write data selection
   always_comb begin
      sp_m1 = sp_ff - SP_W'(1);
      sp_m2 = sp_ff - SP_W'(2);
      case (cmd.addr_sel)
         ADDR_TOP:   ram_addr = sp_m1[ADDR_W-1:0];
         ADDR_BELOW: ram_addr = sp_m2[ADDR_W-1:0];
         ADDR_FREE:  ram_addr = sp_ff[ADDR_W-1:0];
         default:    ram_addr = sp_ff[ADDR_W-1:0];
      endcase
      case (cmd.wd_sel)
         WD_PUSH: ram_wdata = value_ff;
         WD_READ: ram_wdata = ram_rdata;
         WD_HOLD: ram_wdata = hold_ff;
         default: ram_wdata = value_ff;
      endcase
   end

   // Request capture, pointer update and swap holding register
   always_comb begin
      op_in    = cmd.latch_req ? op_type'(req_tuser) : op_ff;
      value_in = cmd.latch_req ? req_tdata : value_ff;
      hold_in  = cmd.hold_load ? ram_rdata : hold_ff;
      case (cmd.sp_op)
         SP_KEEP:  sp_in = sp_ff;
         SP_INC:   sp_in = sp_ff + SP_W'(1);
         SP_DEC:   sp_in = sp_m1;
         SP_CLEAR: sp_in = '0;
         default:  sp_in = sp_ff;
      endcase
   end

   // Output register: load on finish, drop once taken
   always_comb begin
      depth_wide   = {{DEPTH_W{1'b0}}, sp_in};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      result_in    = result_ff;
      status_in    = status_ff;
      depth_in     = depth_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         status_in    = cmd.status;
         depth_in     = depth_wide[DEPTH_W-1:0];
         case (cmd.res_sel)
            RES_ZERO:  result_in = '0;
            RES_EMPTY: result_in = '1;
            RES_READ:  result_in = ram_rdata;
            default:   result_in = '0;
         endcase
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sp_ff        <= sp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      hold_ff   <= hold_in;
      result_ff <= result_in;
      status_ff <= status_in;
      depth_ff  <= depth_in;
   end

   // Status towards the controller
   always_comb begin
      stat.op        = op_ff;
      stat.empty     = (sp_ff == '0);
      stat.full      = (sp_ff == SP_W'(STACK_DEPTH));
      stat.short_stk = (sp_ff < SP_W'(2));
      stat.slot_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'({depth_ff, status_ff, result_ff});

endmodule

// ===== rtl/operand_stack_with_dup_swap_unit.sv =====
`timescale 1ns / 1ps
// Operand stack: a last-in-first-out store of signed 32-bit words.
// Request channel (req_): req_tuser carries the operation (push, pop, peek,
// duplicate, swap, clear), req_tdata the word to push. Every request beat
// produces exactly one response beat on rsp_: the popped or peeked word
// (all ones when empty, zero otherwise), a status code and the depth left.
// One request is worked on at a time. Push, clear, unused codes and any
// refused operation finish in the execute step; pop and peek read the top
// word, then answer; duplicate reads the top word, then writes it into the
// free slot; swap reads the top word, reads the one below, then writes the
// lower word on top and the old top word below it. These steps follow from
// the single-port stack RAM with a registered read: one read or one write
// per cycle.
// A response register sits on the output; the next request is accepted while
// a response is still waiting. If the receiver stalls, the following request
// holds in its last step until the register frees, and req_tready stays low.
// Synchronous reset empties the stack and drops any pending response; no
// clearing pass is needed, as only written entries are ever read.
module operand_stack_with_dup_swap_unit import opstk_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [31:0] push_value
   input  logic [OP_W-1:0]        req_tuser,  // [2:0] req_type
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata   // [31:0] result_value, [33:32] status,
                                              // [41:34] depth_now, [47:42] zero
);

   cmd_type  cmd;
   stat_type stat;

   opstk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   opstk_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/opstk_checker.sv =====
`timescale 1ns / 1ps
`include "operand_stack_with_dup_swap_unit_defines.svh"

module opstk_checker import opstk_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic [REQ_TDATA_W-1:0] req_tdata,
   input logic [OP_W-1:0]        req_tuser,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam logic [SP_W+DEPTH_W-1:0] FULL_WIDE = (SP_W+DEPTH_W)'(STACK_DEPTH);

   logic               rsp_beat;
   st_type             rsp_status;
   logic [DEPTH_W-1:0] rsp_depth;
   logic               req_seen;

   assign rsp_beat   = rsp_tvalid;
   assign rsp_status = st_type'(rsp_tdata[STATUS_LSB +: STATUS_W]);
   assign rsp_depth  = rsp_tdata[DEPTH_LSB +: DEPTH_W];
   assign req_seen   = req_tvalid && req_tready && (req_tdata == req_tdata)
                       && (req_tuser == req_tuser);

   // A stalled response keeps its contents
   `OPSTK_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // One request at a time: no accept right after an accept
   `OPSTK_ASSERT_NEXT(a_one_in_flight, req_seen, !req_tready)

   // Empty status only with nothing held
   `OPSTK_ASSERT_NOW(a_empty_depth, rsp_beat && rsp_status == ST_EMPTY, rsp_depth == '0)

   // Full status only at full depth
   `OPSTK_ASSERT_NOW(a_full_depth, rsp_beat && rsp_status == ST_FULL,
      rsp_depth == FULL_WIDE[DEPTH_W-1:0])

   // Short status only below two entries
   `OPSTK_ASSERT_NOW(a_short_depth, rsp_beat && rsp_status == ST_SHORT,
      rsp_depth < DEPTH_W'(2))

endmodule

bind operand_stack_with_dup_swap_unit opstk_checker u_checker (.*);

// ===== tb/tb_operand_stack_with_dup_swap_unit.sv =====
`timescale 1ns / 1ps

module tb_operand_stack_with_dup_swap_unit import opstk_pkg::*; ();

   // Request codes the block must ignore
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASE_ITEMS  = 383;

   // Bias of the random operation mix
   typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      st_type             status;
      logic [DEPTH_W-1:0] depth;
   } rsp_fields_type;

   // Mirror of the stack contents and the queue of responses it predicts
   class stack_mirror;
      logic [VALUE_W-1:0] words [STACK_DEPTH];
      int unsigned        depth;
      rsp_fields_type     expected_rsp [$];
      int unsigned        mismatches;

      function new();
         depth      = 0;
         mismatches = 0;
      endfunction

      // Apply one accepted request beat and queue the response it causes
      function void apply_request(logic [OP_W-1:0] code, logic [VALUE_W-1:0] word);
         rsp_fields_type     r;
         logic [VALUE_W-1:0] top;
         r.value  = '0;
         r.status = ST_OK;
         case (code)
            OP_PUSH: begin
               if (depth < STACK_DEPTH) begin
                  words[depth] = word;
                  depth++;
               end else begin
                  r.status = ST_FULL;
               end
            end
            OP_POP, OP_PEEK: begin
               if (depth > 0) begin
                  r.value = words[depth-1];
                  if (code == OP_POP) depth--;
               end else begin
                  r.value  = '1;
                  r.status = ST_EMPTY;
               end
            end
            OP_DUP: begin
               if (depth == 0) begin
                  r.status = ST_EMPTY;
               end else if (depth >= STACK_DEPTH) begin
                  r.status = ST_FULL;
               end else begin
                  words[depth] = words[depth-1];
                  depth++;
               end
            end
            OP_SWAP: begin
               if (depth >= 2) begin
                  top            = words[depth-1];
                  words[depth-1] = words[depth-2];
                  words[depth-2] = top;
               end else begin
                  r.status = ST_SHORT;
               end
            end
            OP_CLEAR: depth = 0;
            default: ;
         endcase
         r.depth = DEPTH_W'(depth);
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [VALUE_W-1:0] want,
                                  logic [VALUE_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
         end
      endfunction

      // Compare one accepted response beat with the oldest prediction
      function void check_response(logic [RSP_TDATA_W-1:0] beat);
         rsp_fields_type e;
         if (expected_rsp.size() == 0) begin
            $error("response beat %0h with no request outstanding", beat);
            mismatches++;
            return;
         end
         e = expected_rsp.pop_front();
         compare_field("result_value", e.value, beat[VALUE_W-1:0]);
         compare_field("status", VALUE_W'(e.status),
                       VALUE_W'(beat[STATUS_LSB +: STATUS_W]));
         compare_field("depth_now", VALUE_W'(e.depth),
                       VALUE_W'(beat[DEPTH_LSB +: DEPTH_W]));
         compare_field("padding", '0,
                       VALUE_W'(beat[RSP_TDATA_W-1:DEPTH_LSB+DEPTH_W]));
      endfunction

      function int unsigned pending();
         return expected_rsp.size();
      endfunction
   endclass

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;   // [31:0] push_value
   logic [OP_W-1:0]        req_tuser  = '0;   // [2:0] req_type
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;         // [31:0] result_value, [33:32] status,
                                              // [41:34] depth_now, [47:42] zero

   stack_mirror mirror = new();
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   bit          hold_request  = 1'b0;
   int          hold_left     = 0;
   int          cycle_count   = 0;

   operand_stack_with_dup_swap_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Take response beats; stall at random or for a long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) mirror.check_response(rsp_tdata);
         if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offer one request beat after a random gap and hold it until taken
   task automatic send_request(input logic [OP_W-1:0] code,
                               input logic [VALUE_W-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= code;
      req_tdata  <= word;
      do @(posedge clock); while (!req_tready);
      mirror.apply_request(code, word);
   endtask

   // Drop valid and wait until every predicted response has arrived
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (mirror.pending() != 0);
   endtask

   function automatic logic [VALUE_W-1:0] pick_word();
      case ($urandom_range(15))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return '0;
         3:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_op(mix_type mix);
      int roll = $urandom_range(99);
      case (mix)
         MIX_FILL: begin
            if (roll < 70)      return OP_PUSH;
            else if (roll < 85) return OP_DUP;
            else if (roll < 90) return OP_SWAP;
            else if (roll < 94) return OP_PEEK;
            else if (roll < 98) return OP_POP;
            else if (roll < 99) return OP_SPARE_6;
            else                return OP_SPARE_7;
         end
         MIX_DRAIN: begin
            if (roll < 70)      return OP_POP;
            else if (roll < 80) return OP_PUSH;
            else if (roll < 86) return OP_PEEK;
            else if (roll < 92) return OP_SWAP;
            else if (roll < 95) return OP_DUP;
            else if (roll < 96) return OP_CLEAR;
            else if (roll < 98) return OP_SPARE_6;
            else                return OP_SPARE_7;
         end
         default: begin
            if (roll < 30)      return OP_PUSH;
            else if (roll < 52) return OP_POP;
            else if (roll < 62) return OP_PEEK;
            else if (roll < 72) return OP_DUP;
            else if (roll < 86) return OP_SWAP;
            else if (roll < 90) return OP_CLEAR;
            else if (roll < 95) return OP_SPARE_6;
            else                return OP_SPARE_7;
         end
      endcase
   endfunction

   // Random requests in segments; long fill and drain runs reach both ends
   task automatic run_random(input int n_items);
      int      left;
      int      seg;
      mix_type mix;
      left = n_items;
      mix  = MIX_FILL;
      while (left > 0) begin
         seg = (mix == MIX_EVEN) ? $urandom_range(20, 80) : $urandom_range(200, 260);
         if (seg > left) seg = left;
         repeat (seg) send_request(pick_op(mix), pick_word());
         left -= seg;
         mix = mix_type'($urandom_range(2));
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = 38;
      recv_idle_pct = 67;

      // Empty-stack refusals, then edge words through every operation
      send_request(OP_POP, pick_word());
      send_request(OP_PEEK, pick_word());
      send_request(OP_DUP, pick_word());
      send_request(OP_SWAP, pick_word());
      send_request(OP_PUSH, 32'h7fff_ffff);
      send_request(OP_SWAP, pick_word());
      send_request(OP_DUP, pick_word());
      send_request(OP_PUSH, 32'h8000_0000);
      send_request(OP_SWAP, pick_word());
      send_request(OP_PEEK, pick_word());
      send_request(OP_POP, pick_word());
      send_request(OP_POP, pick_word());
      send_request(OP_POP, pick_word());
      send_request(OP_PUSH, 32'hffff_ffff);
      send_request(OP_PUSH, 32'h0000_0000);
      send_request(OP_SPARE_6, pick_word());
      send_request(OP_SPARE_7, pick_word());
      send_request(OP_CLEAR, pick_word());
      send_request(OP_PEEK, pick_word());
      send_request(OP_PUSH, 32'h5a5a_a5a5);
      send_request(OP_POP, pick_word());
      wait_drained();

      run_random(PHASE_ITEMS);
      wait_drained();

      send_idle_pct = 67;
      recv_idle_pct = 38;
      run_random(PHASE_ITEMS);
      wait_drained();

      // No idling; open with a long receiver hold so the input backs up
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request  = 1'b1;
      run_random(PHASE_ITEMS);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
